@@ design/utc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// utc_pkg: shared types and code tables
// Mapping constants for the UTF-8 to Cyrillic single-byte code converter.
// ----------------------------------------------------------------------------
package utc_pkg;

   localparam int WORD_W  = 32;
   localparam int BOX_N   = 29;
   localparam int K866_N  = 36;
   localparam int K1251_N = 64;

   localparam logic [7:0] SUB_866  = 8'hFF;
   localparam logic [7:0] SUB_1251 = 8'd160;

   // Cyrillic letter ranges of the packed two-byte word
   localparam logic [WORD_W-1:0] CYR_LO_BASE = 32'd53392;
   localparam logic [WORD_W-1:0] CYR_LO_END  = 32'd53440;
   localparam logic [WORD_W-1:0] CYR_HI_BASE = 32'd53632;
   localparam logic [WORD_W-1:0] CYR_HI_END  = 32'd53648;

   localparam logic [WORD_W-1:0] OFS_866_LO  = 32'd53264;
   localparam logic [WORD_W-1:0] OFS_866_HI  = 32'd53408;
   localparam logic [WORD_W-1:0] OFS_1251_LO = 32'd53200;
   localparam logic [WORD_W-1:0] OFS_1251_HI = 32'd53392;

   // double-line box drawing block
   localparam logic [WORD_W-1:0] BOX_LO = 32'hE29590;
   localparam logic [WORD_W-1:0] BOX_HI = 32'hE295AC;

   localparam logic [7:0] BOX866 [BOX_N] = '{
      8'd205, 8'd186, 8'd213, 8'd214, 8'd201, 8'd184, 8'd183, 8'd187, 8'd212, 8'd211,
      8'd200, 8'd190, 8'd189, 8'd188, 8'd198, 8'd199, 8'd204, 8'd181, 8'd182, 8'd185,
      8'd209, 8'd210, 8'd203, 8'd207, 8'd208, 8'd202, 8'd216, 8'd215, 8'd206 };

   localparam logic [23:0] KEY866 [K866_N] = '{
      24'hC2B0, 24'hC2B1, 24'hC2B2, 24'hC2B7, 24'hC3B7, 24'hD081, 24'hD191,
      24'hE281BF, 24'hE28899, 24'hE2889A, 24'hE28988, 24'hE289A1, 24'hE289A4,
      24'hE289A5, 24'hE28CA0, 24'hE28CA1, 24'hE29480, 24'hE29482, 24'hE2948C,
      24'hE29490, 24'hE29494, 24'hE29498, 24'hE2949C, 24'hE294A4, 24'hE294AC,
      24'hE294B4, 24'hE294BC, 24'hE29680, 24'hE29684, 24'hE29688, 24'hE2968C,
      24'hE29690, 24'hE29691, 24'hE29692, 24'hE29693, 24'hE296A0 };

   localparam logic [7:0] VAL866 [K866_N] = '{
      8'd248, 8'd241, 8'd253, 8'd250, 8'd246, 8'd133, 8'd165, 8'd252, 8'd249,
      8'd251, 8'd247, 8'd240, 8'd243, 8'd242, 8'd244, 8'd245, 8'd196, 8'd179,
      8'd218, 8'd191, 8'd192, 8'd217, 8'd195, 8'd180, 8'd194, 8'd193, 8'd197,
      8'd223, 8'd220, 8'd219, 8'd221, 8'd222, 8'd176, 8'd177, 8'd178, 8'd254 };

   localparam logic [23:0] KEY1251 [K1251_N] = '{
      24'hC2A0, 24'hC2A4, 24'hC2A6, 24'hC2A7, 24'hC2A9, 24'hC2AB, 24'hC2AC,
      24'hC2AD, 24'hC2AE, 24'hC2B0, 24'hC2B1, 24'hC2B5, 24'hC2B6, 24'hC2B7,
      24'hC2BB, 24'hD081, 24'hD082, 24'hD083, 24'hD084, 24'hD085, 24'hD086,
      24'hD087, 24'hD088, 24'hD089, 24'hD08A, 24'hD08B, 24'hD08C, 24'hD08E,
      24'hD08F, 24'hD191, 24'hD192, 24'hD193, 24'hD194, 24'hD195, 24'hD196,
      24'hD197, 24'hD198, 24'hD199, 24'hD19A, 24'hD19B, 24'hD19C, 24'hD19E,
      24'hD19F, 24'hD290, 24'hD291,
      24'hE28093, 24'hE28094, 24'hE28098, 24'hE28099, 24'hE2809A, 24'hE2809C,
      24'hE2809D, 24'hE2809E, 24'hE280A0, 24'hE280A1, 24'hE280A2, 24'hE280A6,
      24'hE280B0, 24'hE280B9, 24'hE280BA, 24'hE282AA, 24'hE282AC, 24'hE28496,
      24'hE284A2 };

   localparam logic [7:0] VAL1251 [K1251_N] = '{
      8'd160, 8'd164, 8'd166, 8'd167, 8'd169, 8'd171, 8'd172, 8'd173, 8'd174,
      8'd176, 8'd177, 8'd181, 8'd182, 8'd183, 8'd187, 8'd168, 8'd128, 8'd129,
      8'd170, 8'd189, 8'd178, 8'd175, 8'd163, 8'd138, 8'd140, 8'd142, 8'd141,
      8'd161, 8'd143, 8'd184, 8'd144, 8'd131, 8'd186, 8'd190, 8'd179, 8'd191,
      8'd188, 8'd154, 8'd156, 8'd158, 8'd157, 8'd162, 8'd159, 8'd165, 8'd180,
      8'd150, 8'd151, 8'd145, 8'd146, 8'd130, 8'd147, 8'd148, 8'd132, 8'd134,
      8'd135, 8'd149, 8'd133, 8'd137, 8'd139, 8'd155, 8'd152, 8'd136, 8'd185,
      8'd153 };

   typedef struct packed {
      logic       hit;
      logic [7:0] code;
   } map_result_type;

endpackage
`default_nettype wire

@@ design/utc_map.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// utc_map: packed character word to code byte
// Range offsets for Cyrillic letters, a box table index for 866, then parallel
// compare against the constant key tables of the selected code page.
// ----------------------------------------------------------------------------
module utc_map (
   input  logic                         codepage,
   input  logic [utc_pkg::WORD_W-1:0]   word,
   output utc_pkg::map_result_type      result
);

   logic [7:0] box_off;

   always_comb begin
      result.hit  = 1'b0;
      result.code = 8'h00;
      box_off     = 8'(word[7:0] - utc_pkg::BOX_LO[7:0]);
      if (!codepage) begin
         priority if (word >= utc_pkg::CYR_LO_BASE && word < utc_pkg::CYR_LO_END) begin
            result.hit  = 1'b1;
            result.code = 8'(word - utc_pkg::OFS_866_LO);
         end else if (word >= utc_pkg::CYR_HI_BASE && word < utc_pkg::CYR_HI_END) begin
            result.hit  = 1'b1;
            result.code = 8'(word - utc_pkg::OFS_866_HI);
         end else if (word >= utc_pkg::BOX_LO && word <= utc_pkg::BOX_HI) begin
            result.hit  = 1'b1;
            result.code = utc_pkg::BOX866[box_off[4:0]];
         end else begin
            for (int i = 0; i < utc_pkg::K866_N; i++) begin
               if (word == {8'h00, utc_pkg::KEY866[i]}) begin
                  result.hit  = 1'b1;
                  result.code = utc_pkg::VAL866[i];
               end
            end
         end
      end else begin
         priority if (word >= utc_pkg::CYR_LO_BASE && word < utc_pkg::CYR_LO_END) begin
            result.hit  = 1'b1;
            result.code = 8'(word - utc_pkg::OFS_1251_LO);
         end else if (word >= utc_pkg::CYR_HI_BASE && word < utc_pkg::CYR_HI_END) begin
            result.hit  = 1'b1;
            result.code = 8'(word - utc_pkg::OFS_1251_HI);
         end else begin
            for (int i = 0; i < utc_pkg::K1251_N; i++) begin
               if (word == {8'h00, utc_pkg::KEY1251[i]}) begin
                  result.hit  = 1'b1;
                  result.code = utc_pkg::VAL1251[i];
               end
            end
         end
      end
   end

endmodule
`default_nettype wire

@@ design/utf8_to_cyrillic_codepage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_cyrillic_codepage: UTF-8 stream to single-byte Cyrillic codes
// Converts a UTF-8 byte stream into DOS 866 or 1251 code bytes, one per
// character, with substitutes for broken or unmapped sequences.
// ----------------------------------------------------------------------------
// One UTF-8 byte enters per word on the req side (req_tlast marks the last
// byte of a string); each character leaves as one code byte on the rsp side,
// with rsp_tuser flagging a substitute and rsp_tlast marking the last result
// caused by an input byte. A byte that causes zero or one result does not
// hold the input, so plain text streams at one byte per clock while rsp_tready
// stays high; a byte that causes more than one result (a broken sequence or a
// flush, up to four) holds the input while the result register drains them
// one per clock as rsp_tready allows. A byte passes through an input register,
// then the decode and table compare into the result register. csr_wr_data selects
// the code page (0 = 866, 1 = 1251); write it only while the block is idle.
// ----------------------------------------------------------------------------
module utf8_to_cyrillic_codepage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] utf8_byte
   input  logic       req_tlast,   // string_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] code_byte
   output logic       rsp_tuser,   // [0] substituted
   output logic       rsp_tlast,   // run_end
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   // configuration
   logic codepage_ff;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // open sequence state
   logic [7:0] held_ff [3];
   logic [7:0] held_in [3];
   logic [1:0] held_cnt_ff, held_cnt_in;
   logic [1:0] expect_ff, expect_in;

   // result register: out_cnt_ff substitutes still go ahead of the final word
   logic       out_valid_ff;
   logic [1:0] out_cnt_ff;
   logic [7:0] out_code_ff;
   logic       out_sub_ff;

   // decode
   logic [7:0]                   sub_code;
   logic                         seq_open;
   logic                         is_cont;
   logic [1:0]                   lead_need;
   logic [2:0]                   prefix;
   logic [2:0]                   job_n;
   logic [7:0]                   fin_code;
   logic                         fin_sub;
   logic [utc_pkg::WORD_W-1:0]   word;
   utc_pkg::map_result_type      map_res;

   logic out_free;
   logic job_take;
   logic req_fire;
   logic rsp_fire;

   assign sub_code = codepage_ff ? utc_pkg::SUB_1251 : utc_pkg::SUB_866;
   assign seq_open = (expect_ff != 2'd0) && (held_cnt_ff != 2'd0);
   assign is_cont  = (in_byte_ff[7:6] == 2'b10);

   always_comb begin
      priority if (in_byte_ff[7:5] == 3'b110) begin
         lead_need = 2'd1;
      end else if (in_byte_ff[7:4] == 4'b1110) begin
         lead_need = 2'd2;
      end else if (in_byte_ff[7:3] == 5'b11110) begin
         lead_need = 2'd3;
      end else begin
         lead_need = 2'd0;
      end
   end

   // pack held bytes big-endian with the new byte in the lowest place
   always_comb begin
      unique case (held_cnt_ff)
         2'd1:    word = {16'h0000, held_ff[0], in_byte_ff};
         2'd2:    word = {8'h00, held_ff[0], held_ff[1], in_byte_ff};
         2'd3:    word = {held_ff[0], held_ff[1], held_ff[2], in_byte_ff};
         default: word = {24'h000000, in_byte_ff};
      endcase
   end

   utc_map u_map (
      .codepage (codepage_ff),
      .word     (word),
      .result   (map_res)
   );

   // Every result but the last of a byte is a substitute, so a job is just a
   // count plus the final result.
   always_comb begin
      held_in     = held_ff;
      held_cnt_in = held_cnt_ff;
      expect_in   = expect_ff;
      prefix      = 3'd0;
      job_n       = 3'd0;
      fin_code    = sub_code;
      fin_sub     = 1'b1;
      if (seq_open && is_cont) begin
         if (held_cnt_ff >= expect_ff || held_cnt_ff == 2'd3) begin
            // sequence complete: map the packed word
            job_n       = 3'd1;
            held_cnt_in = 2'd0;
            expect_in   = 2'd0;
            fin_code    = map_res.hit ? map_res.code : sub_code;
            fin_sub     = !map_res.hit;
         end else begin
            held_in[held_cnt_ff] = in_byte_ff;
            held_cnt_in          = held_cnt_ff + 2'd1;
            if (in_last_ff) begin
               // flush lead and all continuation bytes held so far
               job_n       = {1'b0, held_cnt_ff} + 3'd1;
               held_cnt_in = 2'd0;
               expect_in   = 2'd0;
            end
         end
      end else begin
         // drop any broken sequence, then take the byte afresh
         prefix      = seq_open ? {1'b0, held_cnt_ff} : 3'd0;
         held_cnt_in = 2'd0;
         expect_in   = 2'd0;
         if (!in_byte_ff[7]) begin
            job_n    = prefix + 3'd1;
            fin_code = in_byte_ff;
            fin_sub  = 1'b0;
         end else if (lead_need != 2'd0) begin
            if (in_last_ff) begin
               job_n = prefix + 3'd1;
            end else begin
               job_n       = prefix;
               held_in[0]  = in_byte_ff;
               held_cnt_in = 2'd1;
               expect_in   = lead_need;
            end
         end else begin
            job_n = prefix + 3'd1;
         end
      end
   end

   assign rsp_fire   = out_valid_ff && rsp_tready;
   assign out_free   = !out_valid_ff || (rsp_tready && out_cnt_ff == 2'd0);
   assign job_take   = in_valid_ff && (out_free || job_n == 3'd0);
   assign req_tready = !in_valid_ff || job_take;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         codepage_ff  <= 1'b0;
         in_valid_ff  <= 1'b0;
         held_ff      <= '{default: 8'h00};
         held_cnt_ff  <= 2'd0;
         expect_ff    <= 2'd0;
         out_valid_ff <= 1'b0;
         out_cnt_ff   <= 2'd0;
      end else begin
         if (csr_wr_en) begin
            codepage_ff <= csr_wr_data;
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (job_take) begin
            held_ff     <= held_in;
            held_cnt_ff <= held_cnt_in;
            expect_ff   <= expect_in;
         end
         if (job_take && job_n != 3'd0) begin
            out_valid_ff <= 1'b1;
            out_cnt_ff   <= 2'(job_n - 3'd1);
         end else if (rsp_fire) begin
            if (out_cnt_ff != 2'd0) begin
               out_cnt_ff <= out_cnt_ff - 2'd1;
            end else begin
               out_valid_ff <= 1'b0;
            end
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (job_take && job_n != 3'd0) begin
         out_code_ff <= fin_code;
         out_sub_ff  <= fin_sub;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = (out_cnt_ff == 2'd0);
   assign rsp_tdata  = (out_cnt_ff != 2'd0) ? sub_code : out_code_ff;
   assign rsp_tuser  = (out_cnt_ff != 2'd0) ? 1'b1 : out_sub_ff;

endmodule
`default_nettype wire

@@ design/utc_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// utc_checker: port-level checks for the converter
// Watches the stream and configuration ports over time.
// ----------------------------------------------------------------------------
module utc_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic       rsp_tuser,
   input  logic       rsp_tlast,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   logic codepage_ff;

   // track the selected code page from the write port
   always_ff @(posedge clock) begin
      if (reset) begin
         codepage_ff <= 1'b0;
      end else if (csr_wr_en) begin
         codepage_ff <= csr_wr_data;
      end
   end

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // substitute code follows the code page in force
   a_sub_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         ((codepage_ff && rsp_tdata == 8'd160) || (!codepage_ff && rsp_tdata == 8'hFF)))
      else $error("substitute code does not match code page");

   // only substitutes lead a run, and the run drains without gaps
   a_run_body: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |-> rsp_tuser ##1 rsp_tvalid)
      else $error("run of results broken or non-substitute ahead of last");

   // a stalled request waits only behind a busy result side, and holds
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |-> rsp_tvalid
         ##1 (req_tvalid && $stable(req_tdata) && $stable(req_tlast)))
      else $error("req stalled with idle rsp side or changed while stalled");

   // nothing leaves right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind utf8_to_cyrillic_codepage utc_checker u_checker (.*);
`default_nettype wire

@@ verif/utc_code_monitor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_code_monitor: predicts and checks the converter's code bytes
// Watches the byte, code and register ports, runs its own copy of the
// UTF-8 decoder and the code page tables, and compares every code word.
// ----------------------------------------------------------------------------
module utc_code_monitor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic       rsp_tuser,
   input  logic       rsp_tlast,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   output int         mismatch_count,
   output int         codes_pending
);

   localparam logic [7:0] CP866_SUB  = 8'hFF;
   localparam logic [7:0] CP1251_SUB = 8'd160;

   localparam logic [7:0] CP866_BOX [29] = '{
      8'd205, 8'd186, 8'd213, 8'd214, 8'd201, 8'd184, 8'd183, 8'd187, 8'd212,
      8'd211, 8'd200, 8'd190, 8'd189, 8'd188, 8'd198, 8'd199, 8'd204, 8'd181,
      8'd182, 8'd185, 8'd209, 8'd210, 8'd203, 8'd207, 8'd208, 8'd202, 8'd216,
      8'd215, 8'd206 };

   localparam logic [23:0] CP866_KEY [36] = '{
      24'hC2B0, 24'hC2B1, 24'hC2B2, 24'hC2B7, 24'hC3B7, 24'hD081, 24'hD191,
      24'hE281BF, 24'hE28899, 24'hE2889A, 24'hE28988, 24'hE289A1, 24'hE289A4,
      24'hE289A5, 24'hE28CA0, 24'hE28CA1, 24'hE29480, 24'hE29482, 24'hE2948C,
      24'hE29490, 24'hE29494, 24'hE29498, 24'hE2949C, 24'hE294A4, 24'hE294AC,
      24'hE294B4, 24'hE294BC, 24'hE29680, 24'hE29684, 24'hE29688, 24'hE2968C,
      24'hE29690, 24'hE29691, 24'hE29692, 24'hE29693, 24'hE296A0 };

   localparam logic [7:0] CP866_VAL [36] = '{
      8'd248, 8'd241, 8'd253, 8'd250, 8'd246, 8'd133, 8'd165, 8'd252, 8'd249,
      8'd251, 8'd247, 8'd240, 8'd243, 8'd242, 8'd244, 8'd245, 8'd196, 8'd179,
      8'd218, 8'd191, 8'd192, 8'd217, 8'd195, 8'd180, 8'd194, 8'd193, 8'd197,
      8'd223, 8'd220, 8'd219, 8'd221, 8'd222, 8'd176, 8'd177, 8'd178, 8'd254 };

   localparam logic [23:0] CP1251_KEY [64] = '{
      24'hC2A0, 24'hC2A4, 24'hC2A6, 24'hC2A7, 24'hC2A9, 24'hC2AB, 24'hC2AC,
      24'hC2AD, 24'hC2AE, 24'hC2B0, 24'hC2B1, 24'hC2B5, 24'hC2B6, 24'hC2B7,
      24'hC2BB, 24'hD081, 24'hD082, 24'hD083, 24'hD084, 24'hD085, 24'hD086,
      24'hD087, 24'hD088, 24'hD089, 24'hD08A, 24'hD08B, 24'hD08C, 24'hD08E,
      24'hD08F, 24'hD191, 24'hD192, 24'hD193, 24'hD194, 24'hD195, 24'hD196,
      24'hD197, 24'hD198, 24'hD199, 24'hD19A, 24'hD19B, 24'hD19C, 24'hD19E,
      24'hD19F, 24'hD290, 24'hD291,
      24'hE28093, 24'hE28094, 24'hE28098, 24'hE28099, 24'hE2809A, 24'hE2809C,
      24'hE2809D, 24'hE2809E, 24'hE280A0, 24'hE280A1, 24'hE280A2, 24'hE280A6,
      24'hE280B0, 24'hE280B9, 24'hE280BA, 24'hE282AA, 24'hE282AC, 24'hE28496,
      24'hE284A2 };

   localparam logic [7:0] CP1251_VAL [64] = '{
      8'd160, 8'd164, 8'd166, 8'd167, 8'd169, 8'd171, 8'd172, 8'd173, 8'd174,
      8'd176, 8'd177, 8'd181, 8'd182, 8'd183, 8'd187, 8'd168, 8'd128, 8'd129,
      8'd170, 8'd189, 8'd178, 8'd175, 8'd163, 8'd138, 8'd140, 8'd142, 8'd141,
      8'd161, 8'd143, 8'd184, 8'd144, 8'd131, 8'd186, 8'd190, 8'd179, 8'd191,
      8'd188, 8'd154, 8'd156, 8'd158, 8'd157, 8'd162, 8'd159, 8'd165, 8'd180,
      8'd150, 8'd151, 8'd145, 8'd146, 8'd130, 8'd147, 8'd148, 8'd132, 8'd134,
      8'd135, 8'd149, 8'd133, 8'd137, 8'd139, 8'd155, 8'd152, 8'd136, 8'd185,
      8'd153 };

   typedef struct packed {
      logic [7:0] code;
      logic       sub;
      logic       last;
   } code_word_type;

   code_word_type predicted_codes[$];

   logic       codepage;
   logic [7:0] seq_bytes [3];
   logic [1:0] seq_need;
   logic [1:0] seq_held;

   int err_total  = 0;
   int depth_now  = 0;

   assign mismatch_count = err_total;
   assign codes_pending  = depth_now;

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      err_total++;
   endtask

   function automatic code_word_type sub_code();
      code_word_type r;
      r.code = codepage ? CP1251_SUB : CP866_SUB;
      r.sub  = 1'b1;
      r.last = 1'b0;
      return r;
   endfunction

   // map one packed character word onto the current code page
   function automatic code_word_type lookup_code(logic [31:0] w);
      code_word_type r;
      logic [31:0]   diff;
      r = sub_code();
      diff = 32'd0;
      if (!codepage) begin
         if (w >= 32'd53392 && w < 32'd53440) begin
            diff = w - 32'd53264;
            r.code = diff[7:0];
            r.sub = 1'b0;
         end else if (w >= 32'd53632 && w < 32'd53648) begin
            diff = w - 32'd53408;
            r.code = diff[7:0];
            r.sub = 1'b0;
         end else if (w >= 32'hE29590 && w <= 32'hE295AC) begin
            diff = w - 32'hE29590;
            r.code = CP866_BOX[diff[4:0]];
            r.sub = 1'b0;
         end else begin
            for (int i = 0; i < 36; i++) begin
               if (r.sub && w == {8'h00, CP866_KEY[i]}) begin
                  r.code = CP866_VAL[i];
                  r.sub = 1'b0;
               end
            end
         end
      end else begin
         if (w >= 32'd53392 && w < 32'd53440) begin
            diff = w - 32'd53200;
            r.code = diff[7:0];
            r.sub = 1'b0;
         end else if (w >= 32'd53632 && w < 32'd53648) begin
            diff = w - 32'd53392;
            r.code = diff[7:0];
            r.sub = 1'b0;
         end else begin
            for (int i = 0; i < 64; i++) begin
               if (r.sub && w == {8'h00, CP1251_KEY[i]}) begin
                  r.code = CP1251_VAL[i];
                  r.sub = 1'b0;
               end
            end
         end
      end
      return r;
   endfunction

   task automatic clear_sequence();
      seq_held = 2'd0;
      seq_need = 2'd0;
      for (int i = 0; i < 3; i++) seq_bytes[i] = 8'h00;
   endtask

   // one substitute for the lead and for every held continuation byte
   task automatic flush_sequence();
      for (int i = 0; i < seq_held; i++) predicted_codes.push_back(sub_code());
      clear_sequence();
   endtask

   task automatic start_byte(logic [7:0] b);
      logic [1:0] need;
      need = 2'd0;
      if (b[7] == 1'b0) begin
         predicted_codes.push_back('{code: b, sub: 1'b0, last: 1'b0});
      end else begin
         if (b[7:5] == 3'b110) need = 2'd1;
         else if (b[7:4] == 4'b1110) need = 2'd2;
         else if (b[7:3] == 5'b11110) need = 2'd3;
         if (need == 2'd0) begin
            predicted_codes.push_back(sub_code());
         end else begin
            seq_bytes[0] = b;
            seq_held = 2'd1;
            seq_need = need;
         end
      end
   endtask

   task automatic convert_byte(logic [7:0] b, logic end_of_string);
      int          base;
      logic [31:0] w;
      base = predicted_codes.size();
      w = 32'd0;
      if (seq_need != 2'd0 && seq_held != 2'd0) begin
         if (b[7:6] == 2'b10) begin
            if (seq_held >= seq_need || seq_held == 2'd3) begin
               for (int i = 0; i < seq_held; i++) w = (w << 8) | {24'd0, seq_bytes[i]};
               w = (w << 8) | {24'd0, b};
               clear_sequence();
               predicted_codes.push_back(lookup_code(w));
            end else begin
               seq_bytes[seq_held] = b;
               seq_held = seq_held + 2'd1;
            end
         end else begin
            flush_sequence();
            start_byte(b);
         end
      end else begin
         clear_sequence();
         start_byte(b);
      end
      if (end_of_string && seq_held != 2'd0) flush_sequence();
      if (predicted_codes.size() > base)
         predicted_codes[predicted_codes.size() - 1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      code_word_type want;
      if (reset) begin
         predicted_codes.delete();
         clear_sequence();
         codepage = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_codes.size() == 0) begin
               report_mismatch("unexpected code word", rsp_tdata, 0);
            end else begin
               want = predicted_codes.pop_front();
               if (rsp_tdata != want.code) report_mismatch("code byte", rsp_tdata, want.code);
               if (rsp_tuser != want.sub) report_mismatch("substitute flag", rsp_tuser, want.sub);
               if (rsp_tlast != want.last) report_mismatch("last flag", rsp_tlast, want.last);
            end
         end
         if (req_tvalid && req_tready) convert_byte(req_tdata, req_tlast);
         if (csr_wr_en) codepage = csr_wr_data;
      end
      depth_now = predicted_codes.size();
   end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression for the UTF-8 to Cyrillic code page converter
// Feeds directed and random UTF-8 byte strings under both code pages with
// bursty input and a stalling receiver; the code monitor checks each word.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_TICKS = 8;     // two-stage pipe, with margin
   localparam int PHASE_ITEMS  = 65;
   localparam int RAND_PHASES  = 6;
   localparam int HOLDOFF_LEN  = 120;

   localparam logic CP_866  = 1'b0;
   localparam logic CP_1251 = 1'b1;

   typedef struct packed {
      logic [7:0] b;
      logic       l;
   } byte_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;
   logic       rsp_tlast;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;

   int mismatch_count;
   int codes_pending;
   int cycle_count = 0;

   // sender burst shaping
   int burst_left = 0;
   int gap_left   = 0;

   // set by the stimulus, cleared by the receiver once the hold-off is over
   logic holdoff_armed = 1'b0;

   byte_word_type byte_plan[$];

   always #5 clock = ~clock;

   utf8_to_cyrillic_codepage DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // [7:0] utf8_byte
      .req_tlast   (req_tlast),    // string_end
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // [7:0] code_byte
      .rsp_tuser   (rsp_tuser),    // [0] substituted
      .rsp_tlast   (rsp_tlast),    // run_end
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   utc_code_monitor code_monitor (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .codes_pending  (codes_pending)
   );

   // Watchdog: end the run if the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver: cycle through stall patterns of random length. When the
   // stimulus arms a hold-off, drop ready for a long stretch so the block
   // backs up and stalls its input while the sender keeps offering.
   initial begin
      int mode;
      int mode_left;
      int tick;
      int hold_count;
      mode = 0;
      mode_left = 0;
      tick = 0;
      hold_count = 0;
      forever begin
         @(negedge clock);
         tick++;
         if (holdoff_armed) begin
            rsp_tready <= 1'b0;
            hold_count++;
            if (hold_count >= HOLDOFF_LEN) begin
               holdoff_armed = 1'b0;
               hold_count = 0;
            end
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(3, 0);
               mode_left = $urandom_range(60, 10);
            end
            mode_left--;
            case (mode)
               0: rsp_tready <= 1'b1;                    // no stalls
               1: rsp_tready <= (tick % 3) != 0;         // one in three
               2: rsp_tready <= $urandom_range(1, 0) == 1;
               default: rsp_tready <= (tick % 8) < 2;    // mostly stalled
            endcase
         end
      end
   end

   function automatic logic [7:0] rand_byte(int lo, int hi);
      logic [31:0] r;
      r = $urandom_range(hi, lo);
      return r[7:0];
   endfunction

   function automatic void add_byte(logic [7:0] b);
      byte_plan.push_back('{b: b, l: 1'b0});
   endfunction

   function automatic void mark_string_end();
      if (byte_plan.size() > 0) byte_plan[byte_plan.size() - 1].l = 1'b1;
   endfunction

   function automatic void add_continuations(int n);
      for (int i = 0; i < n; i++) add_byte(rand_byte(8'h80, 8'hBF));
   endfunction

   // Append one random character. Most are well-formed characters, many of
   // them table hits; the rest are truncated sequences and loose bytes.
   function automatic void add_random_char();
      int          kind;
      int          need;
      logic [23:0] key;
      kind = $urandom_range(99, 0);
      need = 0;
      key = 24'h0;
      if (kind < 18) begin
         add_byte(rand_byte(8'h00, 8'h7F));
      end else if (kind < 34) begin
         // Cyrillic letters, both ranges
         if ($urandom_range(2, 0) != 0) begin
            add_byte(8'hD0);
            add_byte(rand_byte(8'h90, 8'hBF));
         end else begin
            add_byte(8'hD1);
            add_byte(rand_byte(8'h80, 8'h8F));
         end
      end else if (kind < 48) begin
         // a table key of either code page, read out as UTF-8 bytes
         if ($urandom_range(1, 0) == 1)
            key = utc_pkg::KEY866[$urandom_range(utc_pkg::K866_N - 1, 0)];
         else
            key = utc_pkg::KEY1251[$urandom_range(utc_pkg::K1251_N - 1, 0)];
         if (key[23:16] != 8'h00) add_byte(key[23:16]);
         add_byte(key[15:8]);
         add_byte(key[7:0]);
      end else if (kind < 56) begin
         // double-line box block, two steps past each end included
         add_byte(8'hE2);
         add_byte(8'h95);
         add_byte(rand_byte(8'h8E, 8'hAE));
      end else if (kind < 64) begin
         add_byte(rand_byte(8'hC0, 8'hDF));
         add_continuations(1);
      end else if (kind < 70) begin
         add_byte(rand_byte(8'hE0, 8'hEF));
         add_continuations(2);
      end else if (kind < 75) begin
         add_byte(rand_byte(8'hF0, 8'hF7));
         add_continuations(3);
      end else if (kind < 86) begin
         // truncated sequence: a lead with too few continuation bytes
         need = $urandom_range(3, 1);
         if (need == 1) add_byte(rand_byte(8'hC0, 8'hDF));
         else if (need == 2) add_byte(rand_byte(8'hE0, 8'hEF));
         else add_byte(rand_byte(8'hF0, 8'hF7));
         add_continuations($urandom_range(need - 1, 0));
      end else if (kind < 92) begin
         add_byte(rand_byte(8'h80, 8'hBF));
      end else if (kind < 96) begin
         add_byte(rand_byte(8'hF8, 8'hFF));
      end else begin
         add_byte(rand_byte(8'h00, 8'hFF));
      end
      if ($urandom_range(9, 0) == 0) mark_string_end();
   endfunction

   // Offer one byte and hold it until accepted; gaps open between bursts.
   task automatic send_word(byte_word_type w);
      while (gap_left > 0) begin
         req_tvalid <= 1'b0;
         gap_left--;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w.b;
      req_tlast  <= w.l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(40, 1);
         if ($urandom_range(2, 0) == 0) gap_left = 0;
         else if ($urandom_range(4, 0) == 0) gap_left = $urandom_range(20, 9);
         else gap_left = $urandom_range(8, 1);
      end
   endtask

   // Drive the planned string; the last byte always ends the string so no
   // sequence stays open across a code page change.
   task automatic drive_plan();
      mark_string_end();
      while (byte_plan.size() > 0) send_word(byte_plan.pop_front());
      req_tvalid <= 1'b0;
   endtask

   // Wait for every predicted word, then let the pipe settle.
   task automatic wait_idle();
      while (codes_pending != 0) @(negedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   task automatic write_codepage(logic cp);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cp;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, code page 866: ASCII ends with the zero byte, both
      // Cyrillic ranges, box block top, a list entry, stray bytes, a
      // four-byte character, a broken sequence and a flush at string end.
      write_codepage(CP_866);
      add_byte(8'h00);
      add_byte(8'h7F);
      add_byte(8'hD0); add_byte(8'h90);
      add_byte(8'hD1); add_byte(8'h8F);
      add_byte(8'hE2); add_byte(8'h95); add_byte(8'hAC);
      add_byte(8'hC2); add_byte(8'hB0);
      add_byte(8'hFF);
      add_byte(8'h80);
      add_byte(8'hF0); add_byte(8'h9F); add_byte(8'h98); add_byte(8'h80);
      add_byte(8'hE2); add_byte(8'h94); add_byte(8'h41);
      add_byte(8'hD0);
      drive_plan();
      wait_idle();

      // Directed, code page 1251: letter, list entry, a three-byte hold
      // broken by a new lead at string end, which gives four words at once.
      write_codepage(CP_1251);
      add_byte(8'hD0); add_byte(8'h90);
      add_byte(8'hE2); add_byte(8'h84); add_byte(8'hA2);
      add_byte(8'hF0); add_byte(8'h90); add_byte(8'h80);
      add_byte(8'hC3);
      drive_plan();
      wait_idle();

      // Random phases, alternating code pages; one phase runs into the
      // long receiver hold-off.
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         write_codepage(ph[0] ? CP_866 : CP_1251);
         while (byte_plan.size() < PHASE_ITEMS) add_random_char();
         if (ph == 2) holdoff_armed = 1'b1;
         drive_plan();
         wait_idle();
      end

      repeat (SETTLE_TICKS) @(negedge clock);
      if (mismatch_count == 0 && codes_pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
